// ===== sv/btds_pkg.sv =====
// Package for the byte translate, delete and squeeze filter.
// Holds the command and register codes, the queue entry type and the queue sizing.
// Used by every module of the block but btds_ram; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package btds_pkg;

  // Input command codes
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Configuration register indexes
  localparam int   CFG_INDEX_W      = 1;
  localparam logic REG_DELETE_MODE  = 1'b0;
  localparam logic REG_SQUEEZE_MODE = 1'b1;

  // Queue between the lookup front end and the output back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One byte that survived deletion, with its squeeze mark
  typedef struct packed {
    logic [7:0] sym;
    logic       sq_mark;
  } qentry_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
  } qstatus_t;

endpackage

`default_nettype wire

// ===== sv/byte_translate_delete_squeeze.sv =====
// Byte filter in the manner of tr: each data byte is translated through a table, or, with
// delete mode on, dropped when its delete mark is set and otherwise passed untranslated; with
// squeeze on, repeats of a held squeeze-marked byte are dropped. The block takes one input
// transfer per cycle while in_stall is low and emits at most one byte per cycle. A data byte
// passes two registered table reads (replacement and delete mark, then the squeeze mark of
// the emitted byte), a four-entry queue and the output register. A table write takes one
// transfer and emits nothing; the entry is in effect for the very next byte. After reset
// the table is the identity map with all marks clear at once, with no clearing pass.
// Configuration must be written only while the block is empty.
`timescale 1ns / 1ps
`default_nettype none

module byte_translate_delete_squeeze #(
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [btds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic                             cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             command,
  input  wire logic [7:0]                       byte_value,
  input  wire logic [7:0]                       map_to,
  input  wire logic                             delete_mark,
  input  wire logic                             squeeze_mark,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte
);

  logic               delete_mode;
  logic               squeeze_mode;
  logic               push;
  logic               pop;
  btds_pkg::qentry_t  push_entry;
  btds_pkg::qentry_t  head;
  btds_pkg::qstatus_t q_status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delete_mode  <= 1'b0;
      squeeze_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        btds_pkg::REG_DELETE_MODE:  delete_mode  <= cfg_data;
        btds_pkg::REG_SQUEEZE_MODE: squeeze_mode <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Table lookup and deletion
  btds_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .delete_mode  (delete_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .byte_value   (byte_value),
    .map_to       (map_to),
    .delete_mark  (delete_mark),
    .squeeze_mark (squeeze_mark),
    .q_status     (q_status),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Queue between the two halves
  btds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Squeezing and output
  btds_back u_back (
    .clk          (clk),
    .rst          (rst),
    .squeeze_mode (squeeze_mode),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte)
  );

endmodule

`default_nettype wire

// ===== sv/btds_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// Read during write to the same address returns the old contents.
// Depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module btds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share the clock edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/btds_queue.sv =====
// Four-entry queue that carries surviving bytes from the lookup front end
// to the output back end. Depends on btds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btds_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire btds_pkg::qentry_t push_entry,
  input  wire logic              pop,
  output btds_pkg::qentry_t      head,
  output btds_pkg::qstatus_t     status
);

  btds_pkg::qentry_t                 slots [btds_pkg::QUEUE_DEPTH];
  logic [btds_pkg::QPTR_W-1:0]       wr_ptr;
  logic [btds_pkg::QPTR_W-1:0]       rd_ptr;
  logic [btds_pkg::QCNT_W-1:0]       count;

  // Entry storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head             = slots[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.count     = count;

  // The front end's credit check must keep the queue from overflowing.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (count < btds_pkg::QCNT_W'(btds_pkg::QUEUE_DEPTH) || pop))
    else $error("queue pushed while full");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue popped while empty");

  a_full_ptrs : assert property (@(posedge clk) disable iff (rst)
    (count == btds_pkg::QCNT_W'(btds_pkg::QUEUE_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with full count");

endmodule

`default_nettype wire

// ===== sv/btds_front.sv =====
// Front end: accepts input transfers, writes table entries, looks up the
// replacement and delete mark, drops deleted bytes and reads the squeeze mark.
// Depends on btds_pkg and btds_ram.
`timescale 1ns / 1ps
`default_nettype none

module btds_front #(
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               delete_mode,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               command,
  input  wire logic [7:0]         byte_value,
  input  wire logic [7:0]         map_to,
  input  wire logic               delete_mark,
  input  wire logic               squeeze_mark,
  input  wire btds_pkg::qstatus_t q_status,
  output logic                    push,
  output btds_pkg::qentry_t       push_entry
);

  // Only byte values below both the symbol count and 256 have table entries
  localparam int TABLE_DEPTH = (SYMBOL_COUNT < 256) ? SYMBOL_COUNT : 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam logic [8:0] TABLE_LIMIT = 9'(TABLE_DEPTH);

  logic                   accept;
  logic                   data_accept;
  logic                   in_table;
  logic                   tbl_we;
  logic [TABLE_DEPTH-1:0] entry_vld;
  logic [8:0]             map_rdata;
  logic                   sq_rdata;
  logic [3:0]             credit;

  logic                   s1_valid;
  logic [7:0]             s1_byte;
  logic                   s1_hit;
  logic [7:0]             s1_replace;
  logic                   s1_delete;
  logic [7:0]             s1_sym;
  logic                   s1_keep;
  logic                   s1_sym_in_table;

  logic                   s2_valid;
  logic [7:0]             s2_sym;
  logic                   s2_hit;

  // Hold off new transfers while the queue could not take every byte in flight
  assign credit   = 4'(q_status.count) + 4'(s1_valid) + 4'(s2_valid);
  assign in_stall = (credit >= 4'(btds_pkg::QUEUE_DEPTH));

  assign accept      = in_valid & ~in_stall;
  assign in_table    = ({1'b0, byte_value} < TABLE_LIMIT);
  assign tbl_we      = accept & (command == btds_pkg::CMD_WRITE) & in_table;
  assign data_accept = accept & (command == btds_pkg::CMD_DATA);

  // Written entries are marked; unwritten ones read as identity with clear marks
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (tbl_we) begin
      entry_vld[byte_value[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Replacement byte and delete mark, looked up with the input byte
  btds_ram #(
    .WIDTH (9),
    .DEPTH (TABLE_DEPTH)
  ) u_map_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (byte_value[IDX_W-1:0]),
    .wdata ({map_to, delete_mark}),
    .raddr (byte_value[IDX_W-1:0]),
    .rdata (map_rdata)
  );

  // First stage: the byte whose map entry is being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= data_accept;
    end
    s1_byte <= byte_value;
    s1_hit  <= in_table & entry_vld[byte_value[IDX_W-1:0]];
  end

  // Translate or delete, then form the emitted byte
  assign s1_replace      = s1_hit ? map_rdata[8:1] : s1_byte;
  assign s1_delete       = s1_hit & map_rdata[0];
  assign s1_sym          = delete_mode ? s1_byte : s1_replace;
  assign s1_keep         = s1_valid & ~(delete_mode & s1_delete);
  assign s1_sym_in_table = ({1'b0, s1_sym} < TABLE_LIMIT);

  // Squeeze mark, looked up with the emitted byte
  btds_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_squeeze_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (byte_value[IDX_W-1:0]),
    .wdata (squeeze_mark),
    .raddr (s1_sym[IDX_W-1:0]),
    .rdata (sq_rdata)
  );

  // Second stage: a surviving byte whose squeeze mark is being read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_keep;
    end
    s2_sym <= s1_sym;
    s2_hit <= s1_sym_in_table & entry_vld[s1_sym[IDX_W-1:0]];
  end

  assign push               = s2_valid;
  assign push_entry.sym     = s2_sym;
  assign push_entry.sq_mark = s2_hit & sq_rdata;

  // Bytes in flight plus queued bytes never exceed the queue size.
  a_credit : assert property (@(posedge clk) disable iff (rst)
    credit <= 4'(btds_pkg::QUEUE_DEPTH))
    else $error("more bytes in flight than the queue can hold");

endmodule

`default_nettype wire

// ===== sv/btds_back.sv =====
// Back end: takes bytes from the queue, drops repeats of a held squeeze-marked
// byte and drives the output register. Depends on btds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btds_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               squeeze_mode,
  input  wire btds_pkg::qentry_t  head,
  input  wire btds_pkg::qstatus_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte
);

  logic [7:0] last_byte;
  logic       last_valid;
  logic       drop;
  logic       emit;

  // Take the queue head whenever the output register is free or being emptied
  assign pop  = q_status.not_empty & (~out_valid | ~out_stall);
  assign drop = squeeze_mode & last_valid & (head.sym == last_byte);
  assign emit = pop & ~drop;

  // Held byte follows every emitted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte  <= '0;
      last_valid <= 1'b0;
    end else if (emit) begin
      last_byte  <= head.sq_mark ? head.sym : 8'd0;
      last_valid <= head.sq_mark;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit | (out_valid & out_stall);
    end
    if (emit) begin
      out_byte <= head.sym;
    end
  end

  // The held state must mirror the squeeze mark of the last emitted byte.
  a_held_tracks : assert property (@(posedge clk) disable iff (rst)
    emit |=> (last_valid == $past(head.sq_mark)))
    else $error("held byte state does not follow the emitted byte");

endmodule

`default_nettype wire

// ===== tb/sv/byte_translate_delete_squeeze_checker.sv =====
// Checker for the byte translate, delete and squeeze filter.
// Watches both channels and the register port, predicts the emitted bytes and compares them.
// Depends on btds_pkg for the command and register codes.
`timescale 1ns / 1ps

module byte_translate_delete_squeeze_checker #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [btds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                             cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             command,
  input  logic [7:0]                       byte_value,
  input  logic [7:0]                       map_to,
  input  logic                             delete_mark,
  input  logic                             squeeze_mark,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [7:0]                       out_byte,
  output int                               mismatches,
  output int                               outstanding
);

  import btds_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Own copy of the table, the held byte and the mode bits.
  logic [7:0] replace_tbl [SYMBOL_COUNT];
  logic       delete_tbl  [SYMBOL_COUNT];
  logic       squeeze_tbl [SYMBOL_COUNT];
  logic [7:0] held_byte;
  logic       held_valid;
  logic       delete_on;
  logic       squeeze_on;

  // Bytes that the filter is expected to emit, oldest first.
  logic [7:0] emitted_q [$];

  // Counts a mismatch and reports only the first few of them.
  task automatic flag_mismatch(input bit have_want, input logic [7:0] want,
                               input logic [7:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      if (have_want)
        $display("%0t: out_byte mismatch, expected %h, got %h", $realtime, want, got);
      else
        $display("%0t: out_byte %h emitted with nothing expected", $realtime, got);
    end
  endtask

  always @(posedge clk) begin : predict_filter
    logic [7:0] sym;
    logic [7:0] want;
    logic       keep;
    logic       in_tbl;
    if (rst) begin
      // Reset leaves the identity map with every mark clear.
      for (int i = 0; i < SYMBOL_COUNT; i++) begin
        replace_tbl[i] = 8'(i);
        delete_tbl[i]  = 1'b0;
        squeeze_tbl[i] = 1'b0;
      end
      held_byte   = 8'h00;
      held_valid  = 1'b0;
      delete_on   = 1'b0;
      squeeze_on  = 1'b0;
      mismatches  = 0;
      emitted_q.delete();
      outstanding <= 0;
    end else begin
      // Register writes; an unknown index changes nothing.
      if (cfg_write) begin
        if (cfg_index == REG_DELETE_MODE)
          delete_on = cfg_data;
        else if (cfg_index == REG_SQUEEZE_MODE)
          squeeze_on = cfg_data;
      end

      // An output transfer is compared with the oldest expected byte.
      if (out_valid && !out_stall) begin
        if (emitted_q.size() == 0) begin
          flag_mismatch(1'b0, 8'h00, out_byte);
        end else begin
          want = emitted_q.pop_front();
          if (want !== out_byte)
            flag_mismatch(1'b1, want, out_byte);
        end
      end

      // An input transfer either updates the table or yields zero or one byte.
      if (in_valid && !in_stall) begin
        in_tbl = byte_value < SYMBOL_COUNT;
        if (command == CMD_WRITE) begin
          if (in_tbl) begin
            replace_tbl[byte_value] = map_to;
            delete_tbl[byte_value]  = delete_mark;
            squeeze_tbl[byte_value] = squeeze_mark;
          end
        end else begin
          keep = 1'b1;
          if (delete_on) begin
            // Delete mode passes surviving bytes untranslated.
            if (in_tbl && delete_tbl[byte_value])
              keep = 1'b0;
            sym = byte_value;
          end else begin
            sym = in_tbl ? replace_tbl[byte_value] : byte_value;
          end
          if (keep && squeeze_on && held_valid && sym == held_byte)
            keep = 1'b0;
          // The held byte follows every emitted byte, squeeze on or off.
          if (keep) begin
            held_valid = (sym < SYMBOL_COUNT) && squeeze_tbl[sym];
            held_byte  = held_valid ? sym : 8'h00;
            emitted_q.push_back(sym);
          end
        end
      end

      outstanding <= emitted_q.size();
    end
  end

endmodule

// ===== tb/sv/byte_translate_delete_squeeze_test.sv =====
// Top of the testbench for the byte translate, delete and squeeze filter.
// Drives reset, register writes and input transfers, stalls the output and gives the verdict.
// Depends on btds_pkg, the filter itself and byte_translate_delete_squeeze_checker.
`timescale 1ns / 1ps

module byte_translate_delete_squeeze_test;

  import btds_pkg::*;

  localparam int DRAIN_CYCLES  = 16;
  localparam int SEGMENT_ITEMS = 100;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = REG_DELETE_MODE;
  logic                   cfg_data     = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic                   command      = CMD_DATA;
  logic [7:0]             byte_value   = 8'h00;
  logic [7:0]             map_to       = 8'h00;
  logic                   delete_mark  = 1'b0;
  logic                   squeeze_mark = 1'b0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [7:0]             out_byte;
  int                     mismatches;
  int                     outstanding;

  // Idle percentages of the sender and the receiver.
  int         send_idle = 24;
  int         recv_idle = 75;
  logic [7:0] last_data = 8'h00;

  initial begin
    forever #5 clk = ~clk;
  end

  byte_translate_delete_squeeze dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .byte_value   (byte_value),
    .map_to       (map_to),
    .delete_mark  (delete_mark),
    .squeeze_mark (squeeze_mark),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte)
  );

  byte_translate_delete_squeeze_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .byte_value   (byte_value),
    .map_to       (map_to),
    .delete_mark  (delete_mark),
    .squeeze_mark (squeeze_mark),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle);
  end

  // Safety net against a hung handshake.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // One input transfer, after a random gap; returns at the edge that accepts it.
  task automatic send_item(input logic cmd, input logic [7:0] value, input logic [7:0] repl,
                           input logic del, input logic sq);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    byte_value   <= value;
    map_to       <= repl;
    delete_mark  <= del;
    squeeze_mark <= sq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // A data byte; the unused fields carry random values.
  task automatic send_data(input logic [7:0] value);
    send_item(CMD_DATA, value, 8'($urandom), 1'($urandom), 1'($urandom));
    last_data = value;
  endtask

  // Waits until every expected byte has come out and the pipeline has emptied.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both mode registers while the filter is empty.
  task automatic set_modes(input logic del_mode, input logic sq_mode);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_DELETE_MODE;
    cfg_data  <= del_mode;
    @(posedge clk);
    cfg_index <= REG_SQUEEZE_MODE;
    cfg_data  <= sq_mode;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random traffic, biased towards a small pool of values so that repeats and marks meet.
  task automatic run_random(input int count);
    logic [7:0] pool_base;
    logic [7:0] value;
    int         pick;
    pool_base = 8'($urandom_range(0, 31)) << 3;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        value = ($urandom_range(0, 99) < 70) ? (pool_base | 8'($urandom_range(0, 7)))
                                             : 8'($urandom);
        send_item(CMD_WRITE, value,
                  ($urandom_range(0, 1) != 0) ? (pool_base | 8'($urandom_range(0, 7)))
                                              : 8'($urandom),
                  ($urandom_range(0, 99) < 30), ($urandom_range(0, 99) < 60));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 30)
          value = last_data;
        else if (pick < 70)
          value = pool_base | 8'($urandom_range(0, 7));
        else
          value = 8'($urandom);
        send_data(value);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity map after reset, extremes and alternating bits.
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h55);
    send_data(8'hAA);
    // Table entries at both ends of the index range.
    send_item(CMD_WRITE, 8'hFF, 8'h00, 1'b1, 1'b1);
    send_item(CMD_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1);
    send_data(8'hFF);
    send_data(8'h00);
    send_item(CMD_WRITE, 8'h41, 8'h41, 1'b0, 1'b1);
    send_item(CMD_WRITE, 8'h10, 8'h41, 1'b0, 1'b0);
    // The held byte is tracked with squeeze off and survives a mode change.
    send_data(8'h41);
    set_modes(1'b0, 1'b1);
    send_data(8'h41);
    // The squeeze check uses the translated byte.
    send_data(8'h10);
    // A table write leaves the held byte alone.
    send_item(CMD_WRITE, 8'h20, 8'h20, 1'b0, 1'b0);
    send_data(8'h41);
    send_data(8'h42);
    send_data(8'h41);
    // In delete mode a dropped byte leaves the held byte alone.
    set_modes(1'b1, 1'b1);
    send_data(8'hFF);
    send_data(8'h41);
    send_data(8'h10);
    send_data(8'h00);
    send_data(8'h00);
    set_modes(1'b1, 1'b0);
    send_data(8'h00);
    send_data(8'hFF);

    // Three idling patterns, each through every mode setting.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 24;
          recv_idle = 75;
        end
        1: begin
          send_idle = 75;
          recv_idle = 24;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        set_modes(seg[0], seg[1]);
        run_random(SEGMENT_ITEMS);
      end
    end

    drain();
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
